[sv/scta_pkg.sv]
package scta_pkg;

  // Line length default and scan code constants
  localparam int unsigned LineCapacityDef = 256;

  localparam logic [7:0] PrefixByte   = 8'hE0;
  localparam logic [6:0] CodeLShift   = 7'd42;
  localparam logic [6:0] CodeRShift   = 7'd54;
  localparam logic [6:0] CodeCaps     = 7'd58;
  localparam logic [6:0] CodeLCtrl    = 7'd29;
  localparam logic [6:0] CodeLAlt     = 7'd56;
  localparam logic [6:0] CodeDel      = 7'd83;
  localparam logic [6:0] BackspaceChr = 7'h08;

  // Modifier flag bits
  localparam logic [7:0] ModLCtrl  = 8'h01;
  localparam logic [7:0] ModLAlt   = 8'h02;
  localparam logic [7:0] ModDel    = 8'h04;
  localparam logic [7:0] ModLShift = 8'h20;
  localparam logic [7:0] ModRShift = 8'h40;
  localparam logic [7:0] ModCaps   = 8'h80;
  localparam logic [7:0] ModReboot = ModLCtrl | ModLAlt | ModDel;
  localparam logic [7:0] ModUpper  = ModLShift | ModRShift | ModCaps;

  localparam int unsigned OutDataW = 32;

  // Key state carried from byte to byte
  typedef struct packed {
    logic       prefix;
    logic [7:0] flags;
  } key_state_t;

  // One decoded result
  typedef struct packed {
    logic       reboot;
    logic       caps_lock_on;
    logic       caps_led_update;
    logic       overflow;
    logic       erase;
    logic [7:0] store_index;
    logic [6:0] stored_char;
    logic [6:0] echo_char;
    logic       char_valid;
  } result_t;

  // US layout make code to ASCII
  function automatic logic [6:0] scan_to_ascii(input logic [6:0] code);
    logic [6:0] ch;
    case (code)
      7'd1:    ch = 7'h1B;
      7'd2:    ch = 7'h31;
      7'd3:    ch = 7'h32;
      7'd4:    ch = 7'h33;
      7'd5:    ch = 7'h34;
      7'd6:    ch = 7'h35;
      7'd7:    ch = 7'h36;
      7'd8:    ch = 7'h37;
      7'd9:    ch = 7'h38;
      7'd10:   ch = 7'h39;
      7'd11:   ch = 7'h30;
      7'd12:   ch = 7'h2D;
      7'd13:   ch = 7'h3D;
      7'd14:   ch = 7'h08;
      7'd15:   ch = 7'h09;
      7'd16:   ch = 7'h71;
      7'd17:   ch = 7'h77;
      7'd18:   ch = 7'h65;
      7'd19:   ch = 7'h72;
      7'd20:   ch = 7'h74;
      7'd21:   ch = 7'h79;
      7'd22:   ch = 7'h75;
      7'd23:   ch = 7'h69;
      7'd24:   ch = 7'h6F;
      7'd25:   ch = 7'h70;
      7'd26:   ch = 7'h5B;
      7'd27:   ch = 7'h5D;
      7'd28:   ch = 7'h0A;
      7'd30:   ch = 7'h61;
      7'd31:   ch = 7'h73;
      7'd32:   ch = 7'h64;
      7'd33:   ch = 7'h66;
      7'd34:   ch = 7'h67;
      7'd35:   ch = 7'h68;
      7'd36:   ch = 7'h6A;
      7'd37:   ch = 7'h6B;
      7'd38:   ch = 7'h6C;
      7'd39:   ch = 7'h3B;
      7'd40:   ch = 7'h27;
      7'd41:   ch = 7'h60;
      7'd43:   ch = 7'h5C;
      7'd44:   ch = 7'h7A;
      7'd45:   ch = 7'h78;
      7'd46:   ch = 7'h63;
      7'd47:   ch = 7'h76;
      7'd48:   ch = 7'h62;
      7'd49:   ch = 7'h6E;
      7'd50:   ch = 7'h6D;
      7'd51:   ch = 7'h2C;
      7'd52:   ch = 7'h2E;
      7'd53:   ch = 7'h2F;
      7'd55:   ch = 7'h2A;
      7'd57:   ch = 7'h20;
      7'd74:   ch = 7'h2D;
      7'd78:   ch = 7'h2B;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

[sv/scta_decode.sv]
module scta_decode #(
  parameter int unsigned LINE_CAPACITY = scta_pkg::LineCapacityDef,
  parameter int unsigned CntW          = $clog2(LINE_CAPACITY + 1)
) (
  input  logic [7:0]           scan_byte_i,
  input  scta_pkg::key_state_t state_i,
  input  logic [CntW-1:0]      count_i,
  output scta_pkg::key_state_t state_o,
  output logic [CntW-1:0]      count_o,
  output scta_pkg::result_t    result_o
);

  logic                 up;
  logic [6:0]           code;
  logic [6:0]           ch;
  logic [6:0]           shown;
  logic                 skip_mods;
  logic                 caps_tog;
  logic [7:0]           mask;
  logic [7:0]           flags_d;
  logic [CntW+7:0]      idx_ext;

  assign up      = scan_byte_i[7];
  assign code    = scan_byte_i[6:0];
  assign ch      = scta_pkg::scan_to_ascii(code);
  assign idx_ext = (CntW + 8)'(count_i);

  // Upper-case letters while a shift or caps lock is active
  always_comb begin
    shown = ch;
    if (((state_i.flags & scta_pkg::ModUpper) != 8'h00) && (ch inside {[7'h61:7'h7A]})) begin
      shown = ch - 7'h20;
    end
  end

  // Prefix handling, line count and character path
  always_comb begin
    result_o     = '0;
    state_o      = state_i;
    count_o      = count_i;
    skip_mods    = 1'b0;
    if (state_i.prefix) begin
      state_o.prefix = 1'b0;
      skip_mods      = 1'b1;
    end else if (scan_byte_i == scta_pkg::PrefixByte) begin
      state_o.prefix = 1'b1;
      skip_mods      = 1'b1;
    end else if (!up) begin
      if (ch == scta_pkg::BackspaceChr) begin
        result_o.erase = 1'b1;
        skip_mods      = 1'b1;
        if (count_i != '0) begin
          count_o = count_i - CntW'(1);
        end
      end else if (count_i >= CntW'(LINE_CAPACITY)) begin
        result_o.overflow = 1'b1;
        count_o           = '0;
        skip_mods         = 1'b1;
      end else if (ch != 7'h00) begin
        result_o.char_valid  = 1'b1;
        result_o.echo_char   = shown;
        result_o.stored_char = ch;
        result_o.store_index = idx_ext[7:0];
        count_o              = count_i + CntW'(1);
      end
    end

    // Modifier tracking
    mask     = 8'h00;
    caps_tog = 1'b0;
    case (code)
      scta_pkg::CodeLShift: mask = scta_pkg::ModLShift;
      scta_pkg::CodeRShift: mask = scta_pkg::ModRShift;
      scta_pkg::CodeLCtrl:  mask = scta_pkg::ModLCtrl;
      scta_pkg::CodeLAlt:   mask = scta_pkg::ModLAlt;
      scta_pkg::CodeDel:    mask = scta_pkg::ModDel;
      scta_pkg::CodeCaps:   caps_tog = !up;
      default:              mask = 8'h00;
    endcase
    flags_d = state_i.flags ^ (caps_tog ? scta_pkg::ModCaps : 8'h00);
    flags_d = up ? (flags_d & ~mask) : (flags_d | mask);
    if (!skip_mods) begin
      state_o.flags            = flags_d;
      result_o.caps_led_update = caps_tog;
      result_o.reboot          = (flags_d == scta_pkg::ModReboot);
    end
    result_o.caps_lock_on = state_o.flags[7];
  end

endmodule

[sv/scancode_to_ascii_decoder_unit.sv]
// Channel   Dir  tdata bits  Contents
// s_axis    in   8           scan_byte
// m_axis    out  32          char_valid, echo_char, stored_char, store_index, erase,
//                            overflow, caps_led_update, caps_lock_on, reboot
//
// Each byte is held first in the input register, then passes through the ROM lookup
// and flag update into the result register. One byte per cycle is sustained while
// the output is not stalled; the key state updates as a byte leaves the input
// register. Reset clears key state, line count and both valid flags.
// A stalled output holds its result while the input register still takes one byte.
module scancode_to_ascii_decoder_unit #(
  parameter int unsigned LINE_CAPACITY = scta_pkg::LineCapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] scan_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] char_valid, [7:1] echo_char, [14:8] stored_char, [22:15] store_index,
  // [23] erase, [24] overflow, [25] caps_led_update, [26] caps_lock_on, [27] reboot
  output logic [scta_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(LINE_CAPACITY + 1);

  logic                          in_vld_q;
  logic [7:0]                    in_byte_q;
  logic                          out_vld_q;
  logic [scta_pkg::OutDataW-1:0] out_data_q;
  logic [scta_pkg::OutDataW-1:0] out_data_d;
  scta_pkg::key_state_t          state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  scta_pkg::result_t             result;
  logic                          advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign out_data_d    = scta_pkg::OutDataW'(result);

  scta_decode #(
    .LINE_CAPACITY(LINE_CAPACITY),
    .CntW         (CntW)
  ) u_decode (
    .scan_byte_i(in_byte_q),
    .state_i    (state_q),
    .count_i    (count_q),
    .state_o    (state_d),
    .count_o    (count_d),
    .result_o   (result)
  );

  // Valid flags, key state and line count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '0;
      count_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
        count_q   <= count_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture the byte on input transfer, the result on advance
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

[sv/scta_checker.sv]
module scta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output result changed while stalled");

  // Character fields are zero unless a character was stored
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[22:1] == 22'h0)
    else $error("character fields set without char_valid");

  // Stored, erased and overflowed are exclusive
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[24:23]) &&
                      !(m_axis_tdata[0] && (m_axis_tdata[23] || m_axis_tdata[24])))
    else $error("char_valid, erase and overflow overlap");

  // Reboot needs caps lock off, and no modifier update on a line edit
  a_reboot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[27] |-> !m_axis_tdata[26])
    else $error("reboot flagged with caps lock on");

  a_edit_nomod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[23] || m_axis_tdata[24]) |->
      !m_axis_tdata[25] && !m_axis_tdata[27])
    else $error("modifier result on erase or overflow");

endmodule

bind scancode_to_ascii_decoder_unit scta_checker u_scta_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[test/tb_scancode_to_ascii_decoder_unit.sv]
module tb_scancode_to_ascii_decoder_unit;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned RandomBytes = 150;
  localparam int unsigned PrintCap    = 40;

  // Make codes and release flag used by the stimulus
  localparam logic [7:0] ReleaseFlag = 8'h80;
  localparam logic [7:0] KeyA        = 8'h1E;
  localparam logic [7:0] KeyQ        = 8'h10;
  localparam logic [7:0] KeyZ        = 8'h2C;
  localparam logic [7:0] KeyOne      = 8'h02;
  localparam logic [7:0] KeyBksp     = 8'h0E;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [scta_pkg::OutDataW-1:0] m_axis_tdata;

  // US layout make code to character, one entry per code
  logic [6:0] key_chars [128] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Predicted key state
  logic       drop_next;
  logic [7:0] held_mods;
  int         line_len;

  scta_pkg::result_t pending_decodes [$];

  int  bytes_sent;
  int  results_checked;
  int  mismatch_count;
  int  overflows_seen;
  int  reboots_seen;
  int  cycle_count;
  int  hold_left;
  int  stall_left;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  scancode_to_ascii_decoder_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode one keyboard byte and advance the predicted key state
  function automatic scta_pkg::result_t decode_key_byte(input logic [7:0] b);
    scta_pkg::result_t res;
    logic       skip_mods;
    logic       up;
    logic [6:0] ch;
    logic [6:0] shown;
    logic [7:0] mask;
    res       = '0;
    skip_mods = 1'b0;
    if (drop_next) begin
      drop_next = 1'b0;
      skip_mods = 1'b1;
    end else if (b == scta_pkg::PrefixByte) begin
      drop_next = 1'b1;
      skip_mods = 1'b1;
    end else if (!b[7]) begin
      ch = key_chars[b[6:0]];
      if (ch == scta_pkg::BackspaceChr) begin
        res.erase = 1'b1;
        if (line_len > 0) line_len--;
        skip_mods = 1'b1;
      end else if (line_len >= int'(scta_pkg::LineCapacityDef)) begin
        res.overflow = 1'b1;
        line_len     = 0;
        skip_mods    = 1'b1;
      end else if (ch != 7'h00) begin
        shown = ch;
        if ((held_mods & scta_pkg::ModUpper) != 8'h00 && ch >= 7'h61 && ch <= 7'h7A) begin
          shown = ch - 7'd32;
        end
        res.char_valid  = 1'b1;
        res.echo_char   = shown;
        res.stored_char = ch;
        res.store_index = line_len[7:0];
        line_len++;
      end
    end
    // Update modifiers on make and break codes
    if (!skip_mods) begin
      up   = b[7];
      mask = 8'h00;
      case (b[6:0])
        scta_pkg::CodeLShift: mask = scta_pkg::ModLShift;
        scta_pkg::CodeRShift: mask = scta_pkg::ModRShift;
        scta_pkg::CodeLCtrl:  mask = scta_pkg::ModLCtrl;
        scta_pkg::CodeLAlt:   mask = scta_pkg::ModLAlt;
        scta_pkg::CodeDel:    mask = scta_pkg::ModDel;
        scta_pkg::CodeCaps: begin
          if (!up) begin
            held_mods           = held_mods ^ scta_pkg::ModCaps;
            res.caps_led_update = 1'b1;
          end
        end
        default: ;
      endcase
      if (up) held_mods = held_mods & ~mask;
      else held_mods = held_mods | mask;
      if (held_mods == scta_pkg::ModReboot) res.reboot = 1'b1;
    end
    res.caps_lock_on = (held_mods & scta_pkg::ModCaps) != 8'h00;
    return res;
  endfunction

  // Offer one byte, hold it until the transfer, then record its expected result
  task automatic type_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 17));
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_decodes.push_back(decode_key_byte(b));
    bytes_sent++;
  endtask

  // Make code of a key that stores a character
  function automatic logic [7:0] pick_char_code();
    logic [7:0] code;
    do begin
      code = 8'($urandom_range(0, 127));
    end while (key_chars[code[6:0]] == 7'h00 ||
               key_chars[code[6:0]] == scta_pkg::BackspaceChr);
    return code;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < PrintCap) begin
      $display("mismatch result %0d: %s got 0x%0h want 0x%0h",
               results_checked, field, got, want);
    end
    mismatch_count++;
  endtask

  // Receiver readiness: long hold on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = int'($urandom_range(1, 17)) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest expected result
  always @(posedge clk_i) begin
    scta_pkg::result_t got;
    scta_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = scta_pkg::result_t'(m_axis_tdata[$bits(scta_pkg::result_t)-1:0]);
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected transfer", int'(got), 0);
      end else begin
        want = pending_decodes.pop_front();
        if (got.char_valid != want.char_valid)
          report_mismatch("char_valid", got.char_valid, want.char_valid);
        if (got.echo_char != want.echo_char)
          report_mismatch("echo_char", got.echo_char, want.echo_char);
        if (got.stored_char != want.stored_char)
          report_mismatch("stored_char", got.stored_char, want.stored_char);
        if (got.store_index != want.store_index)
          report_mismatch("store_index", got.store_index, want.store_index);
        if (got.erase != want.erase)
          report_mismatch("erase", got.erase, want.erase);
        if (got.overflow != want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
        if (got.caps_led_update != want.caps_led_update)
          report_mismatch("caps_led_update", got.caps_led_update, want.caps_led_update);
        if (got.caps_lock_on != want.caps_lock_on)
          report_mismatch("caps_lock_on", got.caps_lock_on, want.caps_lock_on);
        if (got.reboot != want.reboot)
          report_mismatch("reboot", got.reboot, want.reboot);
        if (want.overflow) overflows_seen++;
        if (want.reboot) reboots_seen++;
      end
      results_checked++;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("scancode_to_ascii_decoder_unit test failed");
      $finish;
    end
  end

  // Short directed walk through keys, modifiers, prefix and reboot
  task automatic test_basic_keys();
    type_byte(KeyBksp);                         // erase on an empty line
    type_byte(8'h00);                           // make code with no character
    type_byte(KeyA);
    type_byte({1'b0, scta_pkg::CodeLShift});
    type_byte(KeyA);                            // upper-cased echo
    type_byte(KeyOne);                          // digit stays as is under shift
    type_byte({1'b1, scta_pkg::CodeLShift});
    type_byte({1'b0, scta_pkg::CodeRShift});
    type_byte(KeyQ);
    type_byte({1'b1, scta_pkg::CodeRShift});
    type_byte({1'b0, scta_pkg::CodeCaps});      // caps on
    type_byte({1'b1, scta_pkg::CodeCaps});
    type_byte(KeyZ);
    type_byte({1'b0, scta_pkg::CodeCaps});      // caps off
    type_byte(KeyBksp);
    type_byte(scta_pkg::PrefixByte);
    type_byte(KeyA);                            // dropped after prefix
    type_byte(scta_pkg::PrefixByte);
    type_byte(scta_pkg::PrefixByte);            // prefix byte itself dropped
    type_byte({1'b0, scta_pkg::CodeLCtrl});
    type_byte({1'b0, scta_pkg::CodeLAlt});
    type_byte({1'b0, scta_pkg::CodeDel});       // reboot combination
    type_byte({1'b1, scta_pkg::CodeLCtrl});
    type_byte({1'b1, scta_pkg::CodeLAlt});
    type_byte({1'b1, scta_pkg::CodeDel});
    type_byte(8'hFF);
    type_byte(8'h7F);
  endtask

  // Fill the line to capacity, then overflow on a modifier make code
  task automatic test_line_full();
    while (line_len < int'(scta_pkg::LineCapacityDef)) begin
      type_byte(pick_char_code());
    end
    type_byte({1'b0, scta_pkg::CodeLShift});    // overflow, shift is not taken
    type_byte(KeyA);                            // stored at index zero, lower case
    type_byte({1'b1, scta_pkg::CodeLShift});
  endtask

  // Hold the receiver off while the sender keeps offering bytes
  task automatic test_output_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (24) type_byte(pick_char_code());
    idle_on = 1'b1;
  endtask

  // Mostly well-formed typing with random keys, plus noise bytes
  task automatic test_random_typing();
    int         start;
    int         pick;
    int         n;
    int         j;
    logic [7:0] code;
    logic [7:0] swap;
    logic [7:0] combo [3];
    start = bytes_sent;
    while (bytes_sent - start < int'(RandomBytes)) begin
      // Toggle idling in stretches, none near the end
      if (bytes_sent - start >= int'(RandomBytes) - 70) begin
        idle_on = 1'b0;
      end else if (((bytes_sent - start) % 40) == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        code = pick_char_code();
        type_byte(code);
        if ($urandom_range(0, 9) < 7) type_byte(code | ReleaseFlag);
      end else if (pick < 60) begin
        code = $urandom_range(0, 1) ? {1'b0, scta_pkg::CodeLShift} :
                                      {1'b0, scta_pkg::CodeRShift};
        type_byte(code);
        n = $urandom_range(1, 4);
        repeat (n) type_byte(pick_char_code());
        type_byte(code | ReleaseFlag);
      end else if (pick < 65) begin
        type_byte({1'b0, scta_pkg::CodeCaps});
        type_byte({1'b1, scta_pkg::CodeCaps});
      end else if (pick < 72) begin
        type_byte(KeyBksp);
        if ($urandom_range(0, 1)) type_byte(KeyBksp | ReleaseFlag);
      end else if (pick < 78) begin
        type_byte(scta_pkg::PrefixByte);
        type_byte(8'($urandom_range(0, 255)));
      end else if (pick < 84) begin
        combo[0] = {1'b0, scta_pkg::CodeLCtrl};
        combo[1] = {1'b0, scta_pkg::CodeLAlt};
        combo[2] = {1'b0, scta_pkg::CodeDel};
        // Mix the press order
        for (int k = 2; k > 0; k--) begin
          j        = int'($urandom_range(0, k));
          swap     = combo[k];
          combo[k] = combo[j];
          combo[j] = swap;
        end
        foreach (combo[i]) type_byte(combo[i]);
        if ($urandom_range(0, 2) == 0) type_byte({1'b0, scta_pkg::CodeLShift});
        foreach (combo[i]) type_byte(combo[i] | ReleaseFlag);
        type_byte({1'b1, scta_pkg::CodeLShift});
      end else begin
        type_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    drop_next = 1'b0;
    held_mods = 8'h00;
    line_len  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_keys();
    test_line_full();
    test_output_backpressure();
    test_random_typing();

    // Drain outstanding results, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d key bytes, checked %0d results (%0d line overflows, %0d reboots)",
             bytes_sent, results_checked, overflows_seen, reboots_seen);
    $display("covered prefix drops, shift and caps echo, backspace, full line, backpressure");
    if (mismatch_count == 0) begin
      $display("scancode_to_ascii_decoder_unit test passed");
    end else begin
      $display("scancode_to_ascii_decoder_unit test failed");
    end
    $finish;
  end

endmodule
